@@ sv/query_string_tokenize_decode_macros.svh @@
// assertion macros for the query string tokenizer
// no dependencies; included by the top level only
`ifndef QUERY_STRING_TOKENIZE_DECODE_MACROS_SVH
`define QUERY_STRING_TOKENIZE_DECODE_MACROS_SVH

// condition must never hold outside reset
`define QSTD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("qstd assertion failed");

// consequent holds in the same cycle as the antecedent
`define QSTD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qstd assertion failed");

// consequent holds in the cycle after the antecedent
`define QSTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qstd assertion failed");

`endif

@@ sv/qstd_pkg.sv @@
// types, constants and helpers shared by the query string tokenizer
// no dependencies
`timescale 1ns / 1ps

package qstd_pkg;

  localparam int unsigned QdDepth = 4;
  localparam int unsigned QdPtrW  = $clog2(QdDepth);

  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPct     = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] SepReset  = 8'h26;

  typedef enum logic [2:0] {
    PH_NAME,
    PH_VALUE,
    PH_SKIPWS,
    PH_ESC1,
    PH_ESC2
  } phase_e;

  typedef enum logic [1:0] {
    REC_NAME  = 2'd0,
    REC_VALUE = 2'd1,
    REC_END   = 2'd2
  } rec_type_e;

  typedef struct packed {
    rec_type_e   rtype;
    logic [7:0]  data;
    logic [7:0]  arg;
    logic [11:0] nlen;
    logic [11:0] alen;
    logic        vp;
    logic        done;
  } rec_t;

  // one queue entry holds the records caused by one input beat
  typedef struct packed {
    logic two;
    rec_t r0;
    rec_t r1;
  } entry_t;

  function automatic logic [7:0] hex_digit(input logic [7:0] d);
    if (d <= 8'h39) begin
      return d - 8'h30;
    end else if (d <= 8'h46) begin
      return d - 8'h37;
    end else if (d <= 8'h66) begin
      return d - 8'h57;
    end else begin
      return 8'h00;
    end
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic has_value(input phase_e ph);
    return (ph == PH_VALUE) || (ph == PH_ESC1) || (ph == PH_ESC2);
  endfunction

endpackage

@@ sv/qstd_front.sv @@
// parser front end: separator register, parse state, record building
// depends on qstd_pkg
`timescale 1ns / 1ps

module qstd_front #(
  parameter int MAX_LEN  = 4095,
  parameter int MAX_ARGS = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_string_i,
  output logic             push_o,
  output qstd_pkg::entry_t entry_o
);
  import qstd_pkg::*;

  localparam int LenW = ($clog2(MAX_LEN + 1) > 12) ? $clog2(MAX_LEN + 1) : 12;
  localparam int ArgW = ($clog2(MAX_ARGS + 1) > 8) ? $clog2(MAX_ARGS + 1) : 8;

  logic [7:0]      sep_q, sep_d;
  phase_e          phase_q, phase_d, ph_eff;
  logic [7:0]      esc_q, esc_d;
  logic [LenW-1:0] ncnt_q, ncnt_d, acnt_q, acnt_d;
  logic [ArgW-1:0] arg_q, arg_d;
  rec_t            rec_a, rec_b;
  logic            has_a;

  always_comb begin
    sep_d   = cfg_we_i ? cfg_wdata_i : sep_q;
    phase_d = phase_q;
    esc_d   = esc_q;
    ncnt_d  = ncnt_q;
    acnt_d  = acnt_q;
    arg_d   = arg_q;
    ph_eff  = phase_q;
    has_a   = 1'b0;
    rec_a   = '0;
    rec_b   = '0;
    if (accept_i) begin
      rec_a.arg = arg_q[7:0];
      if ((phase_q == PH_SKIPWS) && is_ws(in_byte_i)) begin
        // skipped whitespace, not counted
      end else if (in_byte_i == sep_q) begin
        has_a      = 1'b1;
        rec_a.rtype = REC_END;
        rec_a.nlen = ncnt_q[11:0];
        rec_a.alen = acnt_q[11:0];
        rec_a.vp   = has_value(phase_q);
        if (arg_q < ArgW'(MAX_ARGS)) begin
          arg_d = ArgW'(arg_q + 1'b1);
        end
        ncnt_d  = '0;
        acnt_d  = '0;
        esc_d   = '0;
        phase_d = PH_SKIPWS;
      end else begin
        if (phase_q == PH_SKIPWS) begin
          ph_eff = PH_NAME;
        end
        phase_d = ph_eff;
        if (acnt_q < LenW'(MAX_LEN)) begin
          acnt_d = LenW'(acnt_q + 1'b1);
        end
        unique case (ph_eff)
          PH_NAME: begin
            if (in_byte_i == ChEq) begin
              phase_d = PH_VALUE;
            end else begin
              if (ncnt_q < LenW'(MAX_LEN)) begin
                ncnt_d = LenW'(ncnt_q + 1'b1);
              end
              has_a       = 1'b1;
              rec_a.rtype = REC_NAME;
              rec_a.data  = in_byte_i;
            end
          end
          PH_VALUE: begin
            if (in_byte_i == ChPct) begin
              esc_d   = '0;
              phase_d = PH_ESC1;
            end else begin
              has_a       = 1'b1;
              rec_a.rtype = REC_VALUE;
              rec_a.data  = (in_byte_i == ChPlus) ? ChSpace : in_byte_i;
            end
          end
          PH_ESC1: begin
            esc_d   = hex_digit(in_byte_i);
            phase_d = PH_ESC2;
          end
          PH_ESC2: begin
            esc_d       = {esc_q[3:0], 4'h0} + hex_digit(in_byte_i);
            has_a       = 1'b1;
            rec_a.rtype = REC_VALUE;
            rec_a.data  = esc_d;
            phase_d     = PH_VALUE;
          end
          default: begin
            phase_d = PH_NAME;
          end
        endcase
      end
      if (end_of_string_i) begin
        rec_b.rtype = REC_END;
        rec_b.arg   = arg_d[7:0];
        rec_b.nlen  = ncnt_d[11:0];
        rec_b.alen  = acnt_d[11:0];
        rec_b.vp    = has_value(phase_d);
        rec_b.done  = 1'b1;
        phase_d     = PH_NAME;
        esc_d       = '0;
        ncnt_d      = '0;
        acnt_d      = '0;
        arg_d       = '0;
      end
    end
  end

  assign push_o      = accept_i && (has_a || end_of_string_i);
  assign entry_o.two = has_a && end_of_string_i;
  assign entry_o.r0  = has_a ? rec_a : rec_b;
  assign entry_o.r1  = rec_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SepReset;
      phase_q <= PH_NAME;
      esc_q   <= '0;
      ncnt_q  <= '0;
      acnt_q  <= '0;
      arg_q   <= '0;
    end else begin
      sep_q   <= sep_d;
      phase_q <= phase_d;
      esc_q   <= esc_d;
      ncnt_q  <= ncnt_d;
      acnt_q  <= acnt_d;
      arg_q   <= arg_d;
    end
  end

endmodule

@@ sv/qstd_fifo.sv @@
// short queue of record entries between the parser and the output stage
// depends on qstd_pkg
`timescale 1ns / 1ps

module qstd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qstd_pkg::entry_t din_i,
  input  logic             pop_i,
  output qstd_pkg::entry_t dout_o,
  output logic             full_o,
  output logic             empty_o
);
  import qstd_pkg::*;

  entry_t              mem_q [QdDepth];
  logic [QdPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QdPtrW:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (QdPtrW + 1)'(QdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? QdPtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? QdPtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = (QdPtrW + 1)'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = (QdPtrW + 1)'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

@@ sv/qstd_back.sv @@
// output stage: holds one entry and hands out its records one beat each
// depends on qstd_pkg
`timescale 1ns / 1ps

module qstd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  qstd_pkg::entry_t q_head_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output qstd_pkg::rec_t   rec_o,
  output logic             run_last_o
);
  import qstd_pkg::*;

  entry_t cur_q, cur_d;
  logic   valid_q, valid_d;
  logic   idx_q, idx_d;
  logic   take, free;

  always_comb begin
    take    = pop_i && valid_q;
    free    = !valid_q || (take && (idx_q || !cur_q.two));
    q_pop_o = free && !q_empty_i;
    valid_d = free ? !q_empty_i : 1'b1;
    cur_d   = q_pop_o ? q_head_i : cur_q;
    idx_d   = free ? 1'b0 : (idx_q || take);
  end

  assign empty_o    = !valid_q;
  assign rec_o      = idx_q ? cur_q.r1 : cur_q.r0;
  assign run_last_o = idx_q || !cur_q.two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

@@ sv/query_string_tokenize_decode.sv @@
// top level of the query string tokenizer and value decoder
// depends on qstd_pkg, qstd_front, qstd_fifo, qstd_back and the macros header
//
//  channel   | handshake         | beat contents
//  ----------+-------------------+--------------------------------------------
//  input     | push / full       | in_byte_i, end_of_string_i
//  result    | empty / pop       | record_type_o .. run_last_o
//  config    | cfg_we_i          | cfg_wdata_i (separator byte)
//
// one input beat per cycle unless full; each beat makes zero, one or two result beats
// a beat that makes two results (a record plus end of string) needs two pops
// a four-entry queue between parser and output stage absorbs result-side stalls
// parser state updates in the accept cycle; a result passes the queue, then the output register
// reset sets the separator to '&' and empties the queue and output stage
`timescale 1ns / 1ps
`include "query_string_tokenize_decode_macros.svh"

module query_string_tokenize_decode #(
  parameter int MAX_LEN  = 4095,
  parameter int MAX_ARGS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_string_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  record_type_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  arg_number_o,
  output logic [11:0] name_length_o,
  output logic [11:0] arg_length_o,
  output logic        value_present_o,
  output logic        string_done_o,
  output logic        run_last_o
);
  import qstd_pkg::*;

  logic   accept, f_push, q_pop, q_empty;
  entry_t f_entry, q_head;
  rec_t   rec;

  assign accept = push && !full;

  qstd_front #(
    .MAX_LEN  (MAX_LEN),
    .MAX_ARGS (MAX_ARGS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .push_o          (f_push),
    .entry_o         (f_entry)
  );

  qstd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .din_i   (f_entry),
    .pop_i   (q_pop),
    .dout_o  (q_head),
    .full_o  (full),
    .empty_o (q_empty)
  );

  qstd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .rec_o      (rec),
    .run_last_o (run_last_o)
  );

  assign record_type_o   = rec.rtype;
  assign out_byte_o      = rec.data;
  assign arg_number_o    = rec.arg;
  assign name_length_o   = rec.nlen;
  assign arg_length_o    = rec.alen;
  assign value_present_o = rec.vp;
  assign string_done_o   = rec.done;

  `QSTD_ASSERT_IMPLIES(a_full_has_out, clk_i, rst_ni, full, !empty)
  `QSTD_ASSERT_IMPLIES(a_done_is_end, clk_i, rst_ni, !empty && string_done_o, (record_type_o == REC_END) && run_last_o)
  `QSTD_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, pop && !empty && !run_last_o, !empty)

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for query_string_tokenize_decode
// parses bytes with its own tokenizer and compares every result beat
// depends on qstd_pkg and the query_string_tokenize_decode rtl
`timescale 1ns / 1ps

module testbench;
  import qstd_pkg::*;

  localparam logic [7:0]  ChZero   = 8'h30;
  localparam logic [7:0]  ChNine   = 8'h39;
  localparam logic [7:0]  ChUpperA = 8'h41;
  localparam logic [7:0]  ChUpperF = 8'h46;
  localparam logic [7:0]  ChLowerA = 8'h61;
  localparam logic [7:0]  ChLowerF = 8'h66;
  localparam logic [11:0] MaxLen   = 12'd4095;
  localparam logic [7:0]  MaxArgs  = 8'd255;
  localparam int unsigned CycleLimit = 1000000;
  localparam int          NumPhases  = 6;
  localparam int          RandomPerPhase = 150;
  localparam int          SettleCycles   = 16;
  localparam string       NameChars  = "abcdefghijkmnopqrstuvwxyz0123456789_-.ABCZ";
  localparam string       HexChars   = "0123456789abcdefABCDEF";

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } raw_byte_t;

  typedef struct {
    rec_type_e   rtype;
    logic [7:0]  data;
    logic [7:0]  arg;
    logic [11:0] nlen;
    logic [11:0] alen;
    logic        vp;
    logic        done;
    logic        last;
  } token_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'h00;
  logic        eos = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  record_type;
  logic [7:0]  out_byte;
  logic [7:0]  arg_number;
  logic [11:0] name_length;
  logic [11:0] arg_length;
  logic        value_present;
  logic        string_done;
  logic        run_last;

  raw_byte_t   raw_bytes[$];
  token_rec_t  pending_records[$];
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          sender_pct = 0;
  int          recv_pct = 0;

  // tokenizer state mirrored by the testbench
  logic [7:0]  sep = SepReset;
  phase_e      ph = PH_NAME;
  logic [7:0]  esc_acc = 8'h00;
  logic [11:0] name_cnt = 12'd0;
  logic [11:0] arg_bytes = 12'd0;
  logic [7:0]  arg_idx = 8'd0;

  query_string_tokenize_decode dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .push            (push),
    .full            (full),
    .in_byte_i       (in_byte),
    .end_of_string_i (eos),
    .empty           (empty),
    .pop             (pop),
    .record_type_o   (record_type),
    .out_byte_o      (out_byte),
    .arg_number_o    (arg_number),
    .name_length_o   (name_length),
    .arg_length_o    (arg_length),
    .value_present_o (value_present),
    .string_done_o   (string_done),
    .run_last_o      (run_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] digit_val(input logic [7:0] d);
    if (d <= ChNine) begin
      return d - ChZero;
    end else if (d <= ChUpperF) begin
      return d + 8'd10 - ChUpperA;
    end else if (d <= ChLowerF) begin
      return d + 8'd10 - ChLowerA;
    end
    return 8'h00;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [11:0] sat_inc(input logic [11:0] x);
    return (x < MaxLen) ? x + 12'd1 : x;
  endfunction

  function automatic token_rec_t byte_rec(input rec_type_e t, input logic [7:0] d);
    token_rec_t r;
    r = '{t, d, arg_idx, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0};
    return r;
  endfunction

  function automatic token_rec_t end_rec(input logic done);
    token_rec_t r;
    logic vp;
    vp = (ph == PH_VALUE) || (ph == PH_ESC1) || (ph == PH_ESC2);
    r = '{REC_END, 8'h00, arg_idx, name_cnt, arg_bytes, vp, done, 1'b0};
    return r;
  endfunction

  function automatic void clear_arg();
    ph = PH_NAME;
    esc_acc = 8'h00;
    name_cnt = 12'd0;
    arg_bytes = 12'd0;
  endfunction

  // advance the mirrored tokenizer by one byte and queue the records it makes
  function automatic void parse_byte(input logic [7:0] c, input logic last);
    token_rec_t recs[$];
    if ((ph == PH_SKIPWS) && is_blank(c)) begin
    end else if (c == sep) begin
      recs.push_back(end_rec(1'b0));
      if (arg_idx < MaxArgs) begin
        arg_idx = arg_idx + 8'd1;
      end
      clear_arg();
      ph = PH_SKIPWS;
    end else begin
      if (ph == PH_SKIPWS) begin
        ph = PH_NAME;
      end
      arg_bytes = sat_inc(arg_bytes);
      case (ph)
        PH_NAME: begin
          if (c == ChEq) begin
            ph = PH_VALUE;
          end else begin
            name_cnt = sat_inc(name_cnt);
            recs.push_back(byte_rec(REC_NAME, c));
          end
        end
        PH_VALUE: begin
          if (c == ChPlus) begin
            recs.push_back(byte_rec(REC_VALUE, ChSpace));
          end else if (c == ChPct) begin
            esc_acc = 8'h00;
            ph = PH_ESC1;
          end else begin
            recs.push_back(byte_rec(REC_VALUE, c));
          end
        end
        PH_ESC1: begin
          esc_acc = digit_val(c);
          ph = PH_ESC2;
        end
        default: begin
          esc_acc = {esc_acc[3:0], 4'h0} + digit_val(c);
          recs.push_back(byte_rec(REC_VALUE, esc_acc));
          ph = PH_VALUE;
        end
      endcase
    end
    if (last) begin
      recs.push_back(end_rec(1'b1));
      clear_arg();
      arg_idx = 8'd0;
    end
    if (recs.size() > 0) begin
      recs[recs.size() - 1].last = 1'b1;
    end
    foreach (recs[i]) begin
      pending_records.push_back(recs[i]);
    end
  endfunction

  task automatic report(input string msg);
    if (mismatches < 100) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string fname, input logic [11:0] got,
                             input logic [11:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", fname, got, want));
    end
  endtask

  task automatic add_byte(input logic [7:0] d, input logic e);
    raw_bytes.push_back('{d, e});
  endtask

  task automatic add_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i], 1'b0);
    end
    if (close) begin
      raw_bytes[raw_bytes.size() - 1].eos = 1'b1;
    end
  endtask

  function automatic logic [7:0] name_char();
    if ($urandom_range(9) == 0) begin
      return 8'($urandom_range(255));
    end
    return NameChars[$urandom_range(NameChars.len() - 1)];
  endfunction

  function automatic logic [7:0] hex_char();
    if ($urandom_range(9) == 0) begin
      return 8'($urandom_range(255));
    end
    return HexChars[$urandom_range(HexChars.len() - 1)];
  endfunction

  task automatic add_value_char();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      add_byte(ChPlus, 1'b0);
    end else if (r < 40) begin
      add_byte(ChPct, 1'b0);
      // an escape is sometimes cut short
      if ($urandom_range(19) != 0) begin
        add_byte(hex_char(), 1'b0);
        add_byte(hex_char(), 1'b0);
      end else if ($urandom_range(1) == 0) begin
        add_byte(hex_char(), 1'b0);
      end
    end else if (r < 90) begin
      add_byte(NameChars[$urandom_range(NameChars.len() - 1)], 1'b0);
    end else begin
      add_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic add_query();
    int nargs;
    int start;
    logic [7:0] blank;
    nargs = $urandom_range(1, 4);
    start = raw_bytes.size();
    for (int a = 0; a < nargs; a++) begin
      if (a > 0) begin
        add_byte(sep, 1'b0);
        if ($urandom_range(9) < 3) begin
          repeat ($urandom_range(1, 2)) begin
            blank = 8'($urandom_range(9, 14));
            add_byte((blank == 8'd14) ? ChSpace : blank, 1'b0);
          end
        end
      end
      repeat ($urandom_range(0, 5)) add_byte(name_char(), 1'b0);
      if ($urandom_range(9) < 7) begin
        add_byte(ChEq, 1'b0);
        repeat ($urandom_range(0, 6)) add_value_char();
      end
    end
    if ($urandom_range(9) == 0) begin
      add_byte(sep, 1'b0);
    end
    if (raw_bytes.size() == start) begin
      add_byte(name_char(), 1'b0);
    end
    raw_bytes[raw_bytes.size() - 1].eos = 1'b1;
  endtask

  always @(posedge clk_i) begin : drive_p
    raw_byte_t beat;
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) begin
        parse_byte(in_byte, eos);
      end
      if ((raw_bytes.size() > 0) && ($urandom_range(99) >= sender_pct)) begin
        beat = raw_bytes.pop_front();
        push <= 1'b1;
        in_byte <= beat.data;
        eos <= beat.eos;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch_p
    token_rec_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_records.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = pending_records.pop_front();
          check_field("record_type", 12'(record_type), 12'(want.rtype));
          check_field("out_byte", 12'(out_byte), 12'(want.data));
          check_field("arg_number", 12'(arg_number), 12'(want.arg));
          check_field("name_length", name_length, want.nlen);
          check_field("arg_length", arg_length, want.alen);
          check_field("value_present", 12'(value_present), 12'(want.vp));
          check_field("string_done", 12'(string_done), 12'(want.done));
          check_field("run_last", 12'(run_last), 12'(want.last));
        end
      end
      pop <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("query_string_tokenize_decode regression: fail");
      $finish;
    end
  end

  initial begin
    logic [7:0] seps[NumPhases];
    int send_mode[4];
    int recv_mode[4];
    int target;
    seps = '{SepReset, 8'h3B, 8'h00, 8'hFF, ChSpace, ChPct};
    send_mode = '{0, 56, 0, 13};
    recv_mode = '{0, 0, 56, 13};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      @(negedge clk_i);
      // phase 0 runs on the reset separator
      if (p > 0) begin
        @(posedge clk_i);
        cfg_we <= 1'b1;
        cfg_wdata <= seps[p];
        sep = seps[p];
        @(posedge clk_i);
        cfg_we <= 1'b0;
        @(negedge clk_i);
      end
      sender_pct = send_mode[p % 4];
      recv_pct = recv_mode[p % 4];
      if (p == 0) begin
        add_text("k=a+b%41%6a%zZ&", 1'b0);
        add_text(" \t&", 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_text("=%4", 1'b1);
        add_text("=%&", 1'b1);
        // saturating argument index
        repeat (300) add_text("a&", 1'b0);
        add_byte("a", 1'b1);
      end
      target = raw_bytes.size() + RandomPerPhase;
      while (raw_bytes.size() < target) begin
        if ($urandom_range(99) < 85) begin
          add_query();
        end else begin
          repeat ($urandom_range(1, 8)) begin
            add_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
          end
        end
      end
      do @(negedge clk_i);
      while ((raw_bytes.size() != 0) || push || (pending_records.size() != 0));
      repeat (SettleCycles) @(negedge clk_i);
    end
    if (mismatches == 0) begin
      $display("query_string_tokenize_decode regression: pass");
    end else begin
      $display("query_string_tokenize_decode regression: fail");
    end
    $finish;
  end

endmodule
